FILE: rtl/encoder_rpm_measure_assert.svh
// ----------------------------------------------------------------------------
// encoder_rpm_measure_assert.svh
// Assertion macros for the encoder speed measurement RTL.
// ----------------------------------------------------------------------------
`ifndef ENCODER_RPM_MEASURE_ASSERT_SVH
`define ENCODER_RPM_MEASURE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define ERM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ERM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/erm_pkg.sv
// ----------------------------------------------------------------------------
// erm_pkg
// Types and constants for the encoder speed measurement block.
// ----------------------------------------------------------------------------
`default_nettype none

package erm_pkg;

    // Field and counter widths
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 1;
    localparam int CNT_W   = 17;
    localparam int MS_W    = 32;
    localparam int RPM_W   = 32;
    localparam int SCALE_W = 20;
    localparam int NUM_W   = CFG_W + SCALE_W;   // target * scale
    localparam int DEN_W   = MS_W + CFG_W;      // ms * pulses per rotation
    localparam int QUOT_W  = NUM_W;
    localparam int STEP_W  = $clog2(QUOT_W + 1);

    // 60 s/min * 1000 ms/s * 16 (four fraction bits)
    localparam logic [SCALE_W-1:0] RPM_SCALE = SCALE_W'(960000);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_PULSES_PER_MEASURE  = 1'b0;
    localparam logic [IDX_W-1:0] REG_PULSES_PER_ROTATION = 1'b1;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/erm_div.sv
// ----------------------------------------------------------------------------
// erm_div
// Restoring divider, one quotient bit per cycle. Operands are latched
// on start; the quotient holds after done until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module erm_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [erm_pkg::NUM_W-1:0]     num,
    input  wire logic [erm_pkg::DEN_W-1:0]     den,
    output erm_pkg::div_stat_t                 stat,
    output logic      [erm_pkg::QUOT_W-1:0]    quot
);

    logic [erm_pkg::DEN_W-1:0]  rem_reg,  rem_next;
    logic [erm_pkg::DEN_W-1:0]  den_reg,  den_next;
    logic [erm_pkg::QUOT_W-1:0] quot_reg, quot_next;
    logic [erm_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic [erm_pkg::DEN_W:0]    shifted;
    logic [erm_pkg::DEN_W:0]    trial;

    // One trial subtraction per cycle
    assign shifted = {rem_reg, quot_reg[erm_pkg::QUOT_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            den_next  = den;
            quot_next = num;
            step_next = erm_pkg::STEP_W'(erm_pkg::QUOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[erm_pkg::DEN_W])
            begin
                rem_next  = shifted[erm_pkg::DEN_W-1:0];
                quot_next = {quot_reg[erm_pkg::QUOT_W-2:0], 1'b0};
            end
            else
            begin
                rem_next  = trial[erm_pkg::DEN_W-1:0];
                quot_next = {quot_reg[erm_pkg::QUOT_W-2:0], 1'b1};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == erm_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

`default_nettype wire

FILE: rtl/encoder_rpm_measure.sv
// ----------------------------------------------------------------------------
// encoder_rpm_measure
// Edge-count tachometer for one encoder channel with an iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one transfer per channel sample with
//   start_req, chan_level and ms_tick. A start sample captures the level and
//   clears the counters; later samples count level changes and ms ticks.
//   While counting, one sample is taken every cycle.
//   When the change count reaches pulses_per_measure + 1 the block stops
//   taking samples: a prep state forms the product terms, then the
//   restoring divider produces 36 quotient bits at one bit per cycle, then
//   the result loads into the output register. With zero elapsed time the
//   divider is skipped and zero_time is raised.
//   Output channel (out_valid/out_ready): one transfer per measurement with
//   rpm_x16 and zero_time. Counting resumes while a result waits; if the next
//   result is ready before the old one is taken, the block holds it and
//   stops taking samples until out_ready.
//   Configuration is written through cfg_we/cfg_index/cfg_data.
//   Reset clears all counters and out_valid; both registers reset to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_rpm_measure (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic [erm_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [erm_pkg::CFG_W-1:0]   cfg_data,
    // sample channel
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        start_req,
    input  wire logic                        chan_level,
    input  wire logic                        ms_tick,
    // result channel
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [erm_pkg::RPM_W-1:0]        rpm_x16,
    output logic                             zero_time
);

    `include "encoder_rpm_measure_assert.svh"

    localparam logic [1:0] ST_COUNT = 2'd0;
    localparam logic [1:0] ST_PREP  = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [erm_pkg::CFG_W-1:0]   ppm_reg, ppm_next;
    logic [erm_pkg::CFG_W-1:0]   ppr_reg, ppr_next;
    logic                        level_reg, level_next;
    logic                        measuring_reg, measuring_next;
    logic [erm_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [erm_pkg::MS_W-1:0]    elapsed_reg, elapsed_next;
    logic                        zero_reg, zero_next;
    logic                        out_valid_reg, out_valid_next;
    logic [erm_pkg::RPM_W-1:0]   rpm_reg, rpm_next;
    logic                        zero_out_reg, zero_out_next;

    logic                        in_fire;
    logic                        out_free;
    logic [erm_pkg::MS_W-1:0]    elapsed_cnt;
    logic [erm_pkg::CNT_W-1:0]   count_cnt;
    logic [erm_pkg::CNT_W-1:0]   target;
    logic                        finish;
    logic [erm_pkg::CFG_W-1:0]   ppr_eff;
    logic [erm_pkg::NUM_W-1:0]   num_mul;
    logic [erm_pkg::DEN_W-1:0]   den_mul;
    logic                        div_start;
    erm_pkg::div_stat_t          div_stat;
    logic [erm_pkg::QUOT_W-1:0]  quot;
    logic [erm_pkg::RPM_W-1:0]   quot_sat;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Counter updates for the current sample
    assign elapsed_cnt = (ms_tick && (elapsed_reg != '1)) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign count_cnt   = ((chan_level != level_reg) && (count_reg != '1))
                         ? count_reg + 1'b1 : count_reg;
    assign target      = {1'b0, ppm_reg} + 1'b1;
    assign finish      = (count_cnt >= target);

    // Operand products, registered inside the divider
    assign ppr_eff   = (ppr_reg == '0) ? erm_pkg::CFG_W'(1) : ppr_reg;
    assign num_mul   = {{erm_pkg::SCALE_W{1'b0}}, ppm_reg}
                     * {{erm_pkg::CFG_W{1'b0}}, erm_pkg::RPM_SCALE};
    assign den_mul   = {{erm_pkg::CFG_W{1'b0}}, elapsed_reg}
                     * {{erm_pkg::MS_W{1'b0}}, ppr_eff};
    // zero_reg is only updated at the end of the prep cycle, so test the count itself
    assign div_start = (state_reg == ST_PREP) && (elapsed_reg != '0);

    // Saturate quotient to 32 bits
    assign quot_sat = (quot[erm_pkg::QUOT_W-1:erm_pkg::RPM_W] != '0)
                      ? '1 : quot[erm_pkg::RPM_W-1:0];

    erm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_mul),
        .den   (den_mul),
        .stat  (div_stat),
        .quot  (quot)
    );

    // Sequencer and counters
    always_comb
    begin
        state_next     = state_reg;
        ppm_next       = ppm_reg;
        ppr_next       = ppr_reg;
        level_next     = level_reg;
        measuring_next = measuring_reg;
        count_next     = count_reg;
        elapsed_next   = elapsed_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        rpm_next       = rpm_reg;
        zero_out_next  = zero_out_reg;
        in_ready       = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                erm_pkg::REG_PULSES_PER_MEASURE:  ppm_next = cfg_data;
                erm_pkg::REG_PULSES_PER_ROTATION: ppr_next = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_COUNT:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    if (start_req)
                    begin
                        level_next     = chan_level;
                        count_next     = '0;
                        elapsed_next   = '0;
                        measuring_next = 1'b1;
                    end
                    else if (measuring_reg)
                    begin
                        level_next   = chan_level;
                        count_next   = count_cnt;
                        elapsed_next = elapsed_cnt;
                        if (finish)
                        begin
                            measuring_next = 1'b0;
                            state_next     = ST_PREP;
                        end
                    end
                end
            end
            ST_PREP:
            begin
                zero_next = (elapsed_reg == '0);
                if (elapsed_reg == '0)
                    state_next = ST_LOAD;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    rpm_next       = zero_reg ? '0 : quot_sat;
                    zero_out_next  = zero_reg;
                    state_next     = ST_COUNT;
                end
            end
            default:
            begin
                state_next = ST_COUNT;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COUNT;
            ppm_reg       <= erm_pkg::CFG_W'(1);
            ppr_reg       <= erm_pkg::CFG_W'(1);
            level_reg     <= 1'b0;
            measuring_reg <= 1'b0;
            count_reg     <= '0;
            elapsed_reg   <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ppm_reg       <= ppm_next;
            ppr_reg       <= ppr_next;
            level_reg     <= level_next;
            measuring_reg <= measuring_next;
            count_reg     <= count_next;
            elapsed_reg   <= elapsed_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        rpm_reg      <= rpm_next;
        zero_out_reg <= zero_out_next;
    end

    assign out_valid = out_valid_reg;
    assign rpm_x16   = rpm_reg;
    assign zero_time = zero_out_reg;

    // Checks
    `ERM_ASSERT_IMP(a_done_in_div, clk, rst_n, div_stat.done, state_reg == ST_DIV,
                    "divider done outside divide state")
    `ERM_ASSERT_IMP(a_div_active, clk, rst_n, state_reg == ST_DIV,
                    div_stat.busy || div_stat.done, "divide state without divider activity")
    `ERM_ASSERT_IMP(a_zero_result, clk, rst_n, out_valid && zero_time, rpm_x16 == '0,
                    "zero time result not zero")
    `ERM_ASSERT_NXT(a_finish_stop, clk, rst_n,
                    in_fire && !start_req && measuring_reg && finish,
                    (state_reg == ST_PREP) && !measuring_reg,
                    "final sample did not end measurement")

endmodule

`default_nettype wire

FILE: dv/erm_checker.sv
// ----------------------------------------------------------------------------
// erm_checker
// Tracks the encoder speed block from its ports, predicts each speed result
// from the accepted samples and register writes, and compares every result
// transfer against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module erm_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [erm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [erm_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        start_req,
    input  logic                        chan_level,
    input  logic                        ms_tick,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [erm_pkg::RPM_W-1:0]   rpm_x16,
    input  logic                        zero_time,
    output int                          fail_count,
    output int                          pending,
    output int                          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [erm_pkg::RPM_W-1:0] rpm;
        logic                      zt;
    } speed_t;

    // expected speed results, oldest first
    speed_t speed_q[$];

    // shadow of the registers and the measurement state
    logic [erm_pkg::CFG_W-1:0] tgt_pulses;
    logic [erm_pkg::CFG_W-1:0] rot_pulses;
    logic                      last_lvl;
    logic                      counting;
    logic [erm_pkg::CNT_W-1:0] changes;
    logic [erm_pkg::MS_W-1:0]  ms_elapsed;

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
    end

    task automatic report(input string what, input logic [erm_pkg::RPM_W-1:0] want,
                          input logic [erm_pkg::RPM_W-1:0] got);
        $display("%0t erm_checker: %s: expected 0x%0h, got 0x%0h", $realtime, what,
                 want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        speed_t      want;

        if (!rst_n)
        begin
            tgt_pulses = 16'd1;
            rot_pulses = 16'd1;
            last_lvl   = 1'b0;
            counting   = 1'b0;
            changes    = '0;
            ms_elapsed = '0;
            speed_q.delete();
        end
        else
        begin
            // result transfer: compare with the oldest prediction
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (speed_q.size() == 0)
                    report("result with nothing expected", '0, rpm_x16);
                else
                begin
                    want = speed_q.pop_front();
                    if (rpm_x16 !== want.rpm)
                        report("rpm_x16 mismatch", want.rpm, rpm_x16);
                    if (zero_time !== want.zt)
                        report("zero_time mismatch", erm_pkg::RPM_W'(want.zt),
                               erm_pkg::RPM_W'(zero_time));
                end
            end

            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    erm_pkg::REG_PULSES_PER_MEASURE:  tgt_pulses = cfg_data;
                    erm_pkg::REG_PULSES_PER_ROTATION: rot_pulses = cfg_data;
                    default: ;
                endcase
            end

            // sample transfer: advance the measurement
            if (in_valid && in_ready)
            begin
                if (start_req)
                begin
                    last_lvl   = chan_level;
                    changes    = '0;
                    ms_elapsed = '0;
                    counting   = 1'b1;
                end
                else if (counting)
                begin
                    // tick saturates; final sample's tick counts too
                    if (ms_tick && ms_elapsed != '1)
                        ms_elapsed++;
                    if (chan_level != last_lvl)
                    begin
                        if (changes != '1)
                            changes++;
                        last_lvl = chan_level;
                    end
                    if (changes >= erm_pkg::CNT_W'(tgt_pulses) + 1'b1)
                    begin
                        counting = 1'b0;
                        if (ms_elapsed == '0)
                        begin
                            want.rpm = '0;
                            want.zt  = 1'b1;
                        end
                        else
                        begin
                            // zero pulses per rotation acts as one
                            num = 64'(tgt_pulses) * 64'(erm_pkg::RPM_SCALE);
                            den = 64'(ms_elapsed) *
                                  64'((rot_pulses == '0) ? erm_pkg::CFG_W'(1) : rot_pulses);
                            quo = num / den;
                            want.rpm = (quo > 64'(erm_pkg::RPM_W'('1)))
                                       ? '1 : quo[erm_pkg::RPM_W-1:0];
                            want.zt  = 1'b0;
                        end
                        speed_q.push_back(want);
                    end
                end
            end
        end
        pending = speed_q.size();
    end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives encoder samples and register writes into the speed measurement
// block: a short directed part for start, restart, zero time, final tick,
// lowered target and a wide rotation count, then random measurements under
// several idle/stall mixes and a long output hold-off.
// erm_checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // no-transfer cycles before giving up; covers hold-off, divider, settling
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int DIV_SETTLE  = 60;     // margin for a divider run

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [erm_pkg::IDX_W-1:0]   cfg_index;
    logic [erm_pkg::CFG_W-1:0]   cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic                        start_req;
    logic                        chan_level;
    logic                        ms_tick;
    logic                        out_valid;
    logic                        out_ready;
    logic [erm_pkg::RPM_W-1:0]   rpm_x16;
    logic                        zero_time;

    int                          fail_count;
    int                          pending;
    int                          results_seen;

    int                          idle_pct;
    int                          stall_pct;
    logic                        hold_req;
    int                          samples_sent;
    logic [erm_pkg::CFG_W-1:0]   cur_tgt;

    encoder_rpm_measure dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_req  (start_req),
        .chan_level (chan_level),
        .ms_tick    (ms_tick),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rpm_x16    (rpm_x16),
        .zero_time  (zero_time)
    );

    erm_checker speed_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_req    (start_req),
        .chan_level   (chan_level),
        .ms_tick      (ms_tick),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rpm_x16      (rpm_x16),
        .zero_time    (zero_time),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin : result_sink
        int hold_left;

        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: ends the run after too long without any transfer
    initial
    begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t watchdog: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
        $display("tb_top: done, errors");
        $finish;
    end

    // one sample transfer, with random idle cycles ahead of it
    task automatic push(input logic s, input logic l, input logic t);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        start_req  <= s;
        chan_level <= l;
        ms_tick    <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        samples_sent++;
    endtask

    // stop offering samples, wait out every expected result and the divider
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DIV_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [erm_pkg::IDX_W-1:0] idx,
                             input logic [erm_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == erm_pkg::REG_PULSES_PER_MEASURE)
            cur_tgt = val;
    endtask

    // start, then enough level changes to finish, with optional restart
    task automatic measure(input int toggle_pct, input int tick_pct,
                           input logic last_tick, input logic broke);
        int   left;
        logic cur;

        cur = 1'($urandom_range(1));
        push(1'b1, cur, 1'($urandom_range(1)));
        left = int'(cur_tgt) + 1;
        while (left > 0)
        begin
            if (broke && left < int'(cur_tgt) + 1)
            begin
                // restart mid-measurement
                broke = 1'b0;
                cur   = 1'($urandom_range(1));
                push(1'b1, cur, 1'($urandom_range(1)));
                left  = int'(cur_tgt) + 1;
            end
            else
            begin
                if ($urandom_range(99) < toggle_pct)
                begin
                    cur = ~cur;
                    left--;
                end
                push(1'b0, cur, (left == 0 && last_tick) ? 1'b1 :
                                ($urandom_range(99) < tick_pct));
            end
        end
        // samples with no measurement running are ignored
        if ($urandom_range(3) == 0)
            push(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // random measurements at one register setting and idle/stall mix
    task automatic run_phase(input logic [erm_pkg::CFG_W-1:0] tgt,
                             input logic [erm_pkg::CFG_W-1:0] ppr,
                             input int idle, input int stall, input logic hold,
                             input int budget);
        int first;
        int tick_pct;

        settle();
        write_reg(erm_pkg::REG_PULSES_PER_MEASURE, tgt);
        write_reg(erm_pkg::REG_PULSES_PER_ROTATION, ppr);
        idle_pct  = idle;
        stall_pct = stall;
        if (hold)
        begin
            @(negedge clk);
            hold_req = 1'b1;
            @(posedge clk);
        end
        first = samples_sent;
        while (samples_sent - first < budget)
        begin
            case ($urandom_range(3))
                0:       tick_pct = 0;
                1:       tick_pct = 5;
                2:       tick_pct = 30;
                default: tick_pct = 100;
            endcase
            measure($urandom_range(30, 100), tick_pct, 1'($urandom_range(1)),
                    $urandom_range(9) == 0);
        end
    endtask

    // stimulus
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        start_req    = 1'b0;
        chan_level   = 1'b0;
        ms_tick      = 1'b0;
        out_ready    = 1'b0;
        hold_req     = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        samples_sent = 0;
        cur_tgt      = 16'd1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: target 1, one pulse per rotation
        // samples before any start are ignored
        push(1'b0, 1'b1, 1'b1);
        push(1'b0, 1'b0, 1'b0);
        // start with tick and level: neither counted
        push(1'b1, 1'b1, 1'b1);
        push(1'b0, 1'b0, 1'b1);
        push(1'b0, 1'b0, 1'b0);
        push(1'b0, 1'b1, 1'b1);
        // no ticks at all: zero time flagged
        push(1'b1, 1'b0, 1'b0);
        push(1'b0, 1'b1, 1'b0);
        push(1'b0, 1'b0, 1'b0);
        // start while measuring restarts
        push(1'b1, 1'b0, 1'b0);
        push(1'b0, 1'b1, 1'b1);
        push(1'b1, 1'b1, 1'b0);
        push(1'b0, 1'b0, 1'b1);
        push(1'b0, 1'b1, 1'b0);
        // only tick arrives with the final change
        push(1'b1, 1'b1, 1'b0);
        push(1'b0, 1'b0, 1'b0);
        push(1'b0, 1'b1, 1'b1);

        // target lowered below the changes already counted
        settle();
        write_reg(erm_pkg::REG_PULSES_PER_MEASURE, 16'd4);
        push(1'b1, 1'b0, 1'b0);
        push(1'b0, 1'b1, 1'b1);
        push(1'b0, 1'b0, 1'b0);
        push(1'b0, 1'b1, 1'b0);
        settle();
        write_reg(erm_pkg::REG_PULSES_PER_MEASURE, 16'd1);
        push(1'b0, 1'b1, 1'b1);

        // target zero, zero pulses per rotation
        settle();
        write_reg(erm_pkg::REG_PULSES_PER_MEASURE, 16'd0);
        write_reg(erm_pkg::REG_PULSES_PER_ROTATION, 16'd0);
        measure(100, 0, 1'b1, 1'b0);
        measure(50, 50, 1'b0, 1'b0);

        // one tick over a longer count with the widest rotation setting
        settle();
        write_reg(erm_pkg::REG_PULSES_PER_MEASURE, 16'd40);
        write_reg(erm_pkg::REG_PULSES_PER_ROTATION, 16'hFFFF);
        measure(100, 0, 1'b1, 1'b0);

        // random measurements
        run_phase(16'd3, 16'd4, 0, 0, 1'b0, 130);
        run_phase(16'd0, 16'hFFFF, 59, 0, 1'b0, 130);
        run_phase(16'd7, 16'd0, 0, 59, 1'b0, 130);
        run_phase(erm_pkg::CFG_W'($urandom_range(1, 15)),
                  erm_pkg::CFG_W'($urandom_range(1, 65535)), 20, 20, 1'b0, 130);
        // result side held off while short measurements keep coming
        run_phase(16'd1, 16'd3, 0, 0, 1'b1, 130);

        settle();
        $display("tb_top: %0d samples sent, %0d speed results checked",
                 samples_sent, results_seen);
        $display("tb_top: small and zero targets, wide rotation counts, restarts, zero time, stalls");
        if (fail_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/erm_pkg.sv
rtl/erm_div.sv
rtl/encoder_rpm_measure.sv
dv/erm_checker.sv
dv/tb_top.sv
